[design/sit_pkg.sv]
`default_nettype none

package sit_pkg;

   localparam int TABLE_DEPTH_DEF  = 64;
   localparam int KEY_BITS_DEF     = 32;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam int MODE_BITS  = 3;
   localparam int POS_BITS   = 6;
   localparam int COUNT_BITS = 7;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_SORTED    = 3'd0,
      MODE_REPLACE   = 3'd1,
      MODE_INSERT_AT = 3'd2,
      MODE_PREPEND   = 3'd3,
      MODE_APPEND    = 3'd4,
      MODE_READ      = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EXISTS = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // per-cell compare result, registered in the accept cycle
   typedef struct packed {
      logic hit;
      logic eq;
   } cell_flag_type;

   // update command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rep;
   } cell_op_type;

endpackage

`default_nettype wire

[design/sit_if.sv]
`default_nettype none

interface sit_req_if
   import sit_pkg::*;
#(
   parameter int KEY_BITS     = KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) ();
   logic                    valid;
   logic                    ready;
   logic [MODE_BITS-1:0]    mode;
   logic [KEY_BITS-1:0]     key;
   logic [PAYLOAD_BITS-1:0] payload;
   logic [POS_BITS-1:0]     position;

   modport source (output valid, output mode, output key, output payload,
                   output position, input ready);
   modport sink   (input valid, input mode, input key, input payload,
                   input position, output ready);
endinterface

interface sit_rsp_if
   import sit_pkg::*;
#(
   parameter int KEY_BITS     = KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic [POS_BITS-1:0]     result_position;
   logic [KEY_BITS-1:0]     read_key;
   logic [PAYLOAD_BITS-1:0] read_payload;
   logic [COUNT_BITS-1:0]   used_count;

   modport source (output valid, output status, output result_position,
                   output read_key, output read_payload, output used_count,
                   input ready);
   modport sink   (input valid, input status, input result_position,
                   input read_key, input read_payload, input used_count,
                   output ready);
endinterface

`default_nettype wire

[design/sit_cell.sv]
`default_nettype none

module sit_cell
   import sit_pkg::*;
#(
   parameter int CELL_INDEX   = 0,
   parameter int IDX_BITS     = 6,
   parameter int CNT_BITS     = 7,
   parameter int KEY_BITS     = KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic [CNT_BITS-1:0]     count,
   input  wire logic                    order_mode,
   input  wire logic                    cmp_en,
   input  wire logic [KEY_BITS-1:0]     cmp_key,
   input  wire cell_op_type             op,
   input  wire logic [IDX_BITS-1:0]     op_idx,
   input  wire logic [KEY_BITS-1:0]     new_key,
   input  wire logic [PAYLOAD_BITS-1:0] new_payload,
   input  wire logic [KEY_BITS-1:0]     left_key,
   input  wire logic [PAYLOAD_BITS-1:0] left_payload,
   input  wire logic [IDX_BITS-1:0]     rd_idx,
   output logic [KEY_BITS-1:0]          key_out,
   output logic [PAYLOAD_BITS-1:0]      payload_out,
   output cell_flag_type                flag,
   output logic [KEY_BITS-1:0]          rd_key,
   output logic [PAYLOAD_BITS-1:0]      rd_payload
);

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);
   localparam logic [CNT_BITS-1:0] MY_CNT = CNT_BITS'(CELL_INDEX);

   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   cell_flag_type           flag_ff, flag_in;
   logic                    used, lower, eq;
   logic [CNT_BITS-1:0]     idx_cnt;

   always_comb begin
      used    = MY_CNT < count;
      eq      = key_ff == cmp_key;
      lower   = order_mode ? (key_ff > cmp_key) : (key_ff < cmp_key);
      flag_in = '{hit: used & (eq | lower), eq: used & eq};
   end

   always_comb begin
      idx_cnt    = CNT_BITS'(op_idx);
      key_in     = key_ff;
      payload_in = payload_ff;
      if (op.rep && MY_IDX == op_idx) begin
         payload_in = new_payload;
      end
      if (op.ins) begin
         if (MY_IDX == op_idx) begin
            key_in     = new_key;
            payload_in = new_payload;
         end else if (MY_CNT > idx_cnt && MY_CNT <= count) begin
            key_in     = left_key;
            payload_in = left_payload;
         end else if (MY_CNT >= count && MY_CNT < idx_cnt) begin
            key_in     = '0;
            payload_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
      if (cmp_en) begin
         flag_ff <= flag_in;
      end
   end

   assign key_out     = key_ff;
   assign payload_out = payload_ff;
   assign flag        = flag_ff;
   assign rd_key      = (rd_idx == MY_IDX) ? key_ff : '0;
   assign rd_payload  = (rd_idx == MY_IDX) ? payload_ff : '0;

endmodule

`default_nettype wire

[design/sit_locate.sv]
`default_nettype none

module sit_locate
   import sit_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int IDX_BITS    = 6
) (
   input  wire logic [TABLE_DEPTH-1:0] hit,
   input  wire logic [TABLE_DEPTH-1:0] eq,
   output logic                        any_hit,
   output logic                        eq_hit,
   output logic [IDX_BITS-1:0]         first_idx
);

   localparam int LEVELS = $clog2(TABLE_DEPTH);

   logic [TABLE_DEPTH-1:0] pre [0:LEVELS];
   logic [TABLE_DEPTH-1:0] first;

   // log-depth inclusive prefix or
   assign pre[0] = hit;
   for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
      for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_bit
         if (i >= (1 << l)) begin : g_or
            assign pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
         end else begin : g_pass
            assign pre[l+1][i] = pre[l][i];
         end
      end
   end

   assign first   = hit & ~(pre[LEVELS] << 1);
   assign any_hit = |hit;
   assign eq_hit  = |(first & eq);

   always_comb begin
      first_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (first[i]) begin
            first_idx = first_idx | IDX_BITS'(i);
         end
      end
   end

endmodule

`default_nettype wire

[design/sorted_insert_table_top.sv]
// Sorted table of up to TABLE_DEPTH key and payload entries held in a row of cells.
// In the cycle a request is accepted every cell compares its stored key against the request
// key; in the execute state that follows, the first matching cell is located and all cells
// shift, load, zero-fill or replace at once while the response word is registered. req
// ready is high only between requests, so one request is in flight at a time; a response
// stalled on rsp ready holds the table in its execute cycle.
// order_mode (csr write) selects descending (0) or ascending (1) key order; write it only
// while idle. Entries are valid only once written; there is no clearing pass after reset.
`default_nettype none

module sorted_insert_table_top
   import sit_pkg::*;
#(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int KEY_BITS     = KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sit_req_if.sink    req_if,
   sit_rsp_if.source  rsp_if,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_wr_data
);

   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int PCW = (CW > POS_BITS) ? CW : POS_BITS;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    order_ff;
   logic [MODE_BITS-1:0]    mode_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [PAYLOAD_BITS-1:0] payload_ff;
   logic [POS_BITS-1:0]     pos_ff;

   logic                    rsp_valid_ff;
   status_type              status_ff;
   logic [POS_BITS-1:0]     res_pos_ff;
   logic [KEY_BITS-1:0]     rd_key_ff;
   logic [PAYLOAD_BITS-1:0] rd_payload_ff;
   logic [COUNT_BITS-1:0]   used_ff;

   logic                    accept, go;
   cell_op_type             op;
   logic [IW-1:0]           op_idx, pos_idx, res_pos;
   status_type              status;
   logic                    ins, rep, rd, full;
   logic [PCW-1:0]          pos_w, cnt_w, depth_w;

   logic [KEY_BITS-1:0]     chain_key     [TABLE_DEPTH];
   logic [PAYLOAD_BITS-1:0] chain_payload [TABLE_DEPTH];
   logic [KEY_BITS-1:0]     cell_rd_key   [TABLE_DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_rd_pay   [TABLE_DEPTH];
   cell_flag_type           flags         [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  hit_vec, eq_vec;
   logic [KEY_BITS-1:0]     rd_key;
   logic [PAYLOAD_BITS-1:0] rd_payload;
   logic                    any_hit, eq_hit;
   logic [IW-1:0]           first_idx;

   assign req_if.ready = state_ff == S_IDLE;
   assign accept       = req_if.valid & req_if.ready;
   assign go           = (state_ff == S_EXEC) & (~rsp_valid_ff | rsp_if.ready);

   // cell row
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0]     left_key;
      logic [PAYLOAD_BITS-1:0] left_payload;
      if (i == 0) begin : g_head
         assign left_key     = '0;
         assign left_payload = '0;
      end else begin : g_link
         assign left_key     = chain_key[i-1];
         assign left_payload = chain_payload[i-1];
      end
      sit_cell #(
         .CELL_INDEX   (i),
         .IDX_BITS     (IW),
         .CNT_BITS     (CW),
         .KEY_BITS     (KEY_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock        (clock),
         .count        (count_ff),
         .order_mode   (order_ff),
         .cmp_en       (accept),
         .cmp_key      (req_if.key),
         .op           (op),
         .op_idx       (op_idx),
         .new_key      (key_ff),
         .new_payload  (payload_ff),
         .left_key     (left_key),
         .left_payload (left_payload),
         .rd_idx       (pos_idx),
         .key_out      (chain_key[i]),
         .payload_out  (chain_payload[i]),
         .flag         (flags[i]),
         .rd_key       (cell_rd_key[i]),
         .rd_payload   (cell_rd_pay[i])
      );
      assign hit_vec[i] = flags[i].hit;
      assign eq_vec[i]  = flags[i].eq;
   end

   sit_locate #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_BITS    (IW)
   ) u_locate (
      .hit       (hit_vec),
      .eq        (eq_vec),
      .any_hit   (any_hit),
      .eq_hit    (eq_hit),
      .first_idx (first_idx)
   );

   always_comb begin
      rd_key     = '0;
      rd_payload = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         rd_key     = rd_key | cell_rd_key[i];
         rd_payload = rd_payload | cell_rd_pay[i];
      end
   end

   // operation decode
   always_comb begin
      pos_w   = PCW'(pos_ff);
      cnt_w   = PCW'(count_ff);
      depth_w = PCW'(TABLE_DEPTH);
      pos_idx = IW'(pos_ff);
      full    = count_ff == CW'(TABLE_DEPTH);
      status  = ST_OK;
      ins     = 1'b0;
      rep     = 1'b0;
      rd      = 1'b0;
      op_idx  = '0;
      res_pos = '0;
      case (mode_type'(mode_ff))
         MODE_READ: begin
            if (pos_w < cnt_w) begin
               rd      = 1'b1;
               res_pos = pos_idx;
            end else begin
               status = ST_BADPOS;
            end
         end
         MODE_SORTED, MODE_REPLACE: begin
            if (full) begin
               status = ST_FULL;
            end else if (any_hit && eq_hit) begin
               if (mode_type'(mode_ff) == MODE_REPLACE) begin
                  rep     = 1'b1;
                  op_idx  = first_idx;
                  res_pos = first_idx;
               end else begin
                  status = ST_EXISTS;
               end
            end else begin
               ins    = 1'b1;
               op_idx = any_hit ? first_idx : IW'(count_ff);
            end
         end
         MODE_INSERT_AT: begin
            if (pos_w >= depth_w) begin
               status = ST_BADPOS;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ins    = 1'b1;
               op_idx = pos_idx;
            end
         end
         MODE_PREPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ins    = 1'b1;
               op_idx = '0;
            end
         end
         MODE_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ins    = 1'b1;
               op_idx = IW'(count_ff);
            end
         end
         default: begin
            status = ST_BADPOS;
         end
      endcase
      if (ins) begin
         res_pos = op_idx;
      end
      op = '{ins: go & ins, rep: go & rep};
   end

   always_comb begin
      count_in = count_ff;
      if (go && ins) begin
         if (CW'(op_idx) < count_ff) begin
            count_in = count_ff + CW'(1);
         end else begin
            count_in = CW'(op_idx) + CW'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_if.mode;
         key_ff     <= req_if.key;
         payload_ff <= req_if.payload;
         pos_ff     <= req_if.position;
      end
      if (go) begin
         status_ff     <= status;
         res_pos_ff    <= (status == ST_OK) ? POS_BITS'(res_pos) : '0;
         rd_key_ff     <= rd ? rd_key : '0;
         rd_payload_ff <= rd ? rd_payload : '0;
         used_ff       <= COUNT_BITS'(count_in);
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = status_ff;
   assign rsp_if.result_position = res_pos_ff;
   assign rsp_if.read_key        = rd_key_ff;
   assign rsp_if.read_payload    = rd_payload_ff;
   assign rsp_if.used_count      = used_ff;

endmodule

`default_nettype wire

[design/sit_chk.sv]
`default_nettype none

module sit_chk
   import sit_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [1:0]            rsp_status,
   input wire logic [POS_BITS-1:0]   rsp_result_position,
   input wire logic [KEY_BITS-1:0]   rsp_read_key,
   input wire logic [COUNT_BITS-1:0] rsp_used_count
);

   // one request in flight: busy in the cycle after a word is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still executing");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("no response word after request");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_position == '0 && rsp_read_key == '0)
      else $error("failed response carries position or key");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_used_count == COUNT_BITS'(TABLE_DEPTH))
      else $error("full status with table not full");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_used_count))
      else $error("stalled response word changed");

endmodule

bind sorted_insert_table_top sit_chk #(
   .TABLE_DEPTH (TABLE_DEPTH),
   .KEY_BITS    (KEY_BITS)
) u_sit_chk (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_status          (rsp_if.status),
   .rsp_result_position (rsp_if.result_position),
   .rsp_read_key        (rsp_if.read_key),
   .rsp_used_count      (rsp_if.used_count)
);

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
   import sit_pkg::*;

   localparam int DEPTH       = TABLE_DEPTH_DEF;
   localparam int KBITS       = KEY_BITS_DEF;
   localparam int PBITS       = PAYLOAD_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [MODE_BITS-1:0] MODE_RSVD_LO = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_RSVD_HI = 3'd7;

   typedef struct {
      status_type            status;
      logic [POS_BITS-1:0]   position;
      logic [KBITS-1:0]      rkey;
      logic [PBITS-1:0]      rpay;
      logic [COUNT_BITS-1:0] used;
   } table_rsp_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   sit_req_if req_ch ();
   sit_rsp_if rsp_ch ();

   sorted_insert_table_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [KBITS-1:0] key_m [DEPTH];
   logic [PBITS-1:0] pay_m [DEPTH];
   int               count_m;
   logic             order_m;

   table_rsp_type pending_results [$];
   int            mismatches;
   int            cycle_count;
   bit            bursts_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got %0h, want %0h", what, got, want);
      mismatches++;
   endtask

   // open a slot, shifting up or zero-filling the gap
   function automatic void place_entry(int slot, logic [KBITS-1:0] k, logic [PBITS-1:0] p);
      int j;
      if (slot < count_m) begin
         for (j = count_m; j > slot; j--) begin
            key_m[j] = key_m[j-1];
            pay_m[j] = pay_m[j-1];
         end
         count_m++;
      end else begin
         for (j = count_m; j < slot; j++) begin
            key_m[j] = '0;
            pay_m[j] = '0;
         end
         count_m = slot + 1;
      end
      key_m[slot] = k;
      pay_m[slot] = p;
   endfunction

   function automatic table_rsp_type apply_table_op(logic [MODE_BITS-1:0] op,
                                                    logic [KBITS-1:0] k,
                                                    logic [PBITS-1:0] p,
                                                    logic [POS_BITS-1:0] pos);
      table_rsp_type r;
      int            slot;
      int            i;
      bit            done;
      bit            replaced;
      r.status   = ST_BADPOS;
      r.position = '0;
      r.rkey     = '0;
      r.rpay     = '0;
      slot       = 0;
      done       = 1'b0;
      replaced   = 1'b0;
      if (op > MODE_READ) begin
         r.status = ST_BADPOS;
      end else if (op == MODE_READ) begin
         if (int'(pos) < count_m) begin
            r.status   = ST_OK;
            r.position = pos;
            r.rkey     = key_m[pos];
            r.rpay     = pay_m[pos];
         end
      end else if (op == MODE_INSERT_AT && int'(pos) >= DEPTH) begin
         r.status = ST_BADPOS;
      end else if (count_m >= DEPTH) begin
         r.status = ST_FULL;
      end else begin
         case (op)
            MODE_SORTED, MODE_REPLACE: begin
               slot = count_m;
               for (i = 0; i < count_m; i++) begin
                  if (!done) begin
                     if (key_m[i] == k) begin
                        done     = 1'b1;
                        replaced = 1'b1;
                        if (op == MODE_REPLACE) begin
                           pay_m[i]   = p;
                           r.status   = ST_OK;
                           r.position = i[POS_BITS-1:0];
                        end else begin
                           r.status = ST_EXISTS;
                        end
                     end else if (order_m ? (key_m[i] > k) : (key_m[i] < k)) begin
                        slot = i;
                        done = 1'b1;
                     end
                  end
               end
            end
            MODE_INSERT_AT: slot = int'(pos);
            MODE_PREPEND:   slot = 0;
            default:        slot = count_m;
         endcase
         if (!replaced) begin
            place_entry(slot, k, p);
            r.status   = ST_OK;
            r.position = slot[POS_BITS-1:0];
         end
      end
      r.used = count_m[COUNT_BITS-1:0];
      return r;
   endfunction

   task automatic send_word(input logic [MODE_BITS-1:0] op, input logic [KBITS-1:0] k,
                            input logic [PBITS-1:0] p, input logic [POS_BITS-1:0] pos);
      int gap;
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid    = 1'b1;
      req_ch.mode     = op;
      req_ch.key      = k;
      req_ch.payload  = p;
      req_ch.position = pos;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(apply_table_op(op, k, p, pos));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_order(input logic ascending);
      wait_drained();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = ascending;
      @(posedge clock);
      order_m = ascending;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("word with nothing pending", 64'(rsp_ch.status), 64'(0));
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
            if (rsp_ch.result_position !== want.position)
               report_mismatch("result_position", 64'(rsp_ch.result_position),
                               64'(want.position));
            if (rsp_ch.read_key !== want.rkey)
               report_mismatch("read_key", 64'(rsp_ch.read_key), 64'(want.rkey));
            if (rsp_ch.read_payload !== want.rpay)
               report_mismatch("read_payload", 64'(rsp_ch.read_payload), 64'(want.rpay));
            if (rsp_ch.used_count !== want.used)
               report_mismatch("used_count", 64'(rsp_ch.used_count), 64'(want.used));
         end
      end
   end

   // result side back-pressure in bursts
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            stall--;
         end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            stall = $urandom_range(1, 16) - 1;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   task automatic test_directed_ops();
      set_order(1'b0);
      send_word(MODE_READ,      32'h0,        32'h0,        6'd0);
      send_word(MODE_RSVD_LO,   32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63);
      send_word(MODE_RSVD_HI,   32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63);
      send_word(MODE_SORTED,    32'h80000000, 32'hFFFFFFFF, 6'd0);
      send_word(MODE_SORTED,    32'hFFFFFFFF, 32'h0,        6'd63);
      send_word(MODE_SORTED,    32'h0,        32'hA5A5A5A5, 6'd0);
      send_word(MODE_SORTED,    32'h80000000, 32'h5A5A5A5A, 6'd0);
      send_word(MODE_REPLACE,   32'h80000000, 32'h12345678, 6'd0);
      send_word(MODE_REPLACE,   32'h00000001, 32'hCAFEF00D, 6'd0);
      send_word(MODE_PREPEND,   32'h00000007, 32'h00000007, 6'd0);
      send_word(MODE_APPEND,    32'hFFFFFFFE, 32'h0000FFFF, 6'd0);
      send_word(MODE_INSERT_AT, 32'h00000055, 32'hFFFF0000, 6'd20);
      send_word(MODE_INSERT_AT, 32'h7FFFFFFF, 32'h80000001, 6'd2);
      send_word(MODE_READ,      32'h0,        32'h0,        6'd10);
      send_word(MODE_READ,      32'h0,        32'h0,        6'd21);
      send_word(MODE_READ,      32'h0,        32'h0,        6'd22);
      send_word(MODE_READ,      32'h0,        32'h0,        6'd63);
      send_word(MODE_READ,      32'h0,        32'h0,        6'd0);
      send_word(MODE_SORTED,    32'h0,        32'h1,        6'd0);
   endtask

   task automatic test_random_mix(input int n_items);
      int                   n;
      int                   roll;
      int                   hi;
      logic [MODE_BITS-1:0] op;
      logic [KBITS-1:0]     k;
      logic [PBITS-1:0]     p;
      logic [POS_BITS-1:0]  pos;
      for (n = 0; n < n_items; n++) begin
         roll = $urandom_range(0, 99);
         k    = $urandom;
         p    = $urandom;
         pos  = POS_BITS'($urandom_range(0, 63));
         if (count_m < DEPTH && roll < 9) begin
            op = MODE_BITS'($urandom_range(0, 4));
            if (op == MODE_INSERT_AT && $urandom_range(0, 39) != 0) begin
               hi  = (count_m + 2 > 63) ? 63 : count_m + 2;
               pos = POS_BITS'($urandom_range(0, hi));
            end
         end else if (roll < 45) begin
            op = MODE_READ;
            if (count_m > 0) pos = POS_BITS'($urandom_range(0, count_m - 1));
         end else if (roll < 55) begin
            op = MODE_READ;
         end else if (roll < 90) begin
            op = (roll < 80) ? MODE_REPLACE : MODE_SORTED;
            if (count_m > 0) k = key_m[$urandom_range(0, count_m - 1)];
         end else if (roll < 95) begin
            op = MODE_BITS'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
         end else begin
            op = MODE_BITS'($urandom_range(0, 5));
         end
         send_word(op, k, p, pos);
      end
   endtask

   task automatic test_full_table();
      if (count_m < DEPTH) send_word(MODE_INSERT_AT, $urandom, $urandom, 6'd63);
      send_word(MODE_SORTED,    $urandom, $urandom, 6'd0);
      send_word(MODE_REPLACE,   key_m[0], $urandom, 6'd0);
      send_word(MODE_INSERT_AT, $urandom, $urandom, 6'd0);
      send_word(MODE_PREPEND,   $urandom, $urandom, 6'd0);
      send_word(MODE_APPEND,    $urandom, $urandom, 6'd63);
      send_word(MODE_READ,      32'h0,    32'h0,    6'd63);
      send_word(MODE_READ,      32'h0,    32'h0,    6'd0);
   endtask

   initial begin
      int i;
      mismatches  = 0;
      bursts_on   = 1'b1;
      count_m     = 0;
      order_m     = 1'b0;
      for (i = 0; i < DEPTH; i++) begin
         key_m[i] = '0;
         pay_m[i] = '0;
      end
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = 1'b0;
      req_ch.valid    = 1'b0;
      req_ch.mode     = '0;
      req_ch.key      = '0;
      req_ch.payload  = '0;
      req_ch.position = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ops();
      set_order(1'b1);
      test_random_mix(300);
      set_order(1'b0);
      test_random_mix(300);
      set_order(1'b1);
      bursts_on = 1'b0;
      test_random_mix(300);
      test_full_table();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
design/sit_pkg.sv
design/sit_if.sv
design/sit_cell.sv
design/sit_locate.sv
design/sorted_insert_table_top.sv
design/sit_chk.sv
bench/tb.sv
